>>> hdl/pssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssd_pkg
// Shared types and constants of the polygon scene stream decoder.
// ----------------------------------------------------------------------------
package pssd_pkg;

   localparam int VtxDepth  = 256;
   localparam int VtxAddrW  = $clog2(VtxDepth);
   localparam int PolyDepth = 16;
   localparam int PolyAddrW = $clog2(PolyDepth);
   localparam int CoordW    = 16;

   localparam logic [7:0] MarkSceneEnd = 8'hfd;
   localparam logic [7:0] MarkSkip     = 8'hfe;
   localparam logic [7:0] MarkFrameEnd = 8'hff;

   typedef enum logic [2:0] {
      KIND_QUAD      = 3'd0,
      KIND_PALETTE   = 3'd1,
      KIND_CLEAR     = 3'd2,
      KIND_FRAME_END = 3'd3,
      KIND_SKIP      = 3'd4,
      KIND_SCENE_END = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      PH_FLAGS, PH_MASK_H, PH_MASK_L, PH_SEEK, PH_COL_H, PH_COL_L,
      PH_VCOUNT, PH_VXY, PH_DESC, PH_IDX, PH_IDX_WB, PH_PX, PH_PY,
      PH_EMIT, PH_EMIT_RD, PH_OUT
   } phase_type;

   // one result word handed to the output register
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  x0, y0, x1, y1, x2, y2, x3, y3;
      logic [3:0]  color_index;
      logic [14:0] palette_color;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

>>> hdl/pssd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pssd_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/polygon_scene_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_scene_stream_decoder
// Parses the scene byte stream; vertex table and polygon corners live in RAM.
// ----------------------------------------------------------------------------
// Output: clear, palette and marker words sit in the output reg in the cycle
// after their byte; quad words come after the corner reads of their step.
// Throughput: one byte per cycle in most phases while the output reg has room;
// an index byte adds a vertex table write-back phase; the mask walk skips clear
// bits; a quad needs four corner reads on the single RAM port, then a reg load.
// Reset: synchronous, clears the parser; RAM contents stay undefined.
// ----------------------------------------------------------------------------
module polygon_scene_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_kind,
   output logic [7:0]       rsp_x0,
   output logic [7:0]       rsp_y0,
   output logic [7:0]       rsp_x1,
   output logic [7:0]       rsp_y1,
   output logic [7:0]       rsp_x2,
   output logic [7:0]       rsp_y2,
   output logic [7:0]       rsp_x3,
   output logic [7:0]       rsp_y3,
   output logic [3:0]       rsp_color_index,
   output logic [14:0]      rsp_palette_color,
   output logic             rsp_last
);

   pssd_pkg::phase_type phase_ff, phase_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic        idx_mode_ff, idx_mode_in;
   logic [15:0] mask_ff, mask_in;
   logic [4:0]  slot_ff, slot_in;
   logic [7:0]  held_ff, held_in;
   logic [3:0]  pcol_ff, pcol_in;
   logic [3:0]  pvc_ff, pvc_in;
   logic [3:0]  ppos_ff, ppos_in;
   // quad emission: current fan step and corner read sequencing
   logic [3:0]  s_ff, s_in;
   logic [1:0]  rd_k_ff, rd_k_in;
   logic [15:0] c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic        outv_ff, outv_in;
   pssd_pkg::result_type out_ff, out_in;

   // vertex table ram
   logic                          vt_we;
   logic [pssd_pkg::VtxAddrW-1:0] vt_wa, vt_ra;
   logic [15:0]                   vt_wd, vt_rd;
   // polygon corner ram
   logic                           pv_we;
   logic [pssd_pkg::PolyAddrW-1:0] pv_wa, pv_ra;
   logic [15:0]                    pv_wd, pv_rd;

   pssd_ram #(.Width(16), .Depth(pssd_pkg::VtxDepth)) u_vtx (
      .clock(clock), .wr_en(vt_we), .wr_addr(vt_wa), .wr_data(vt_wd),
      .rd_addr(vt_ra), .rd_data(vt_rd));
   pssd_ram #(.Width(16), .Depth(pssd_pkg::PolyDepth)) u_poly (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr(pv_ra), .rd_data(pv_rd));

   logic        out_free;
   logic        accept;
   logic [7:0]  b;
   logic [3:0]  maxi;
   logic [3:0]  s_end;
   logic [4:0]  s_next;
   logic [15:0] vxy_word;

   assign out_free  = !outv_ff || !rsp_stall;
   assign b         = req_in_byte;
   assign maxi      = pvc_ff - 4'd1;
   assign s_next    = {1'b0, s_ff} + 5'd2;
   assign s_end     = (s_next > {1'b0, maxi}) ? maxi : s_next[3:0];
   assign vxy_word  = {held_ff, b};

   // take bytes only in byte phases with room in the output register
   always_comb begin
      case (phase_ff)
         pssd_pkg::PH_SEEK, pssd_pkg::PH_IDX_WB, pssd_pkg::PH_EMIT,
         pssd_pkg::PH_EMIT_RD, pssd_pkg::PH_OUT: req_stall = 1'b1;
         default: req_stall = !out_free;
      endcase
   end
   assign accept = req_valid && !req_stall;

   // next state, RAM access and result words
   always_comb begin
      pssd_pkg::result_type r;
      r = '0;
      phase_in = phase_ff; cnt_in = cnt_ff; idx_mode_in = idx_mode_ff;
      mask_in = mask_ff; slot_in = slot_ff; held_in = held_ff;
      pcol_in = pcol_ff; pvc_in = pvc_ff; ppos_in = ppos_ff;
      s_in = s_ff; rd_k_in = rd_k_ff;
      c0_in = c0_ff; c1_in = c1_ff; c2_in = c2_ff; c3_in = c3_ff;
      outv_in = outv_ff && rsp_stall;
      out_in = out_ff;
      vt_we = 1'b0; vt_wa = cnt_ff[pssd_pkg::VtxAddrW:1]; vt_wd = '0;
      vt_ra = b[pssd_pkg::VtxAddrW-1:0];
      pv_we = 1'b0; pv_wa = ppos_ff; pv_wd = vxy_word; pv_ra = '0;
      case (phase_ff)
         pssd_pkg::PH_FLAGS: if (accept) begin
            idx_mode_in = b[2];
            if (b[0]) begin
               r.kind = pssd_pkg::KIND_CLEAR; r.last = 1'b1;
               out_in = r; outv_in = 1'b1;
            end
            phase_in = b[1] ? pssd_pkg::PH_MASK_H :
               (b[2] ? pssd_pkg::PH_VCOUNT : pssd_pkg::PH_DESC);
         end
         pssd_pkg::PH_MASK_H: if (accept) begin
            held_in = b; phase_in = pssd_pkg::PH_MASK_L;
         end
         pssd_pkg::PH_MASK_L: if (accept) begin
            mask_in = {held_ff, b}; slot_in = '0; phase_in = pssd_pkg::PH_SEEK;
         end
         pssd_pkg::PH_SEEK: begin
            // one mask bit per cycle
            if (slot_ff[4]) begin
               phase_in = idx_mode_ff ? pssd_pkg::PH_VCOUNT : pssd_pkg::PH_DESC;
            end else if (mask_ff[15]) begin
               phase_in = pssd_pkg::PH_COL_H;
            end else begin
               mask_in = {mask_ff[14:0], 1'b0}; slot_in = slot_ff + 5'd1;
            end
         end
         pssd_pkg::PH_COL_H: if (accept) begin
            held_in = b; phase_in = pssd_pkg::PH_COL_L;
         end
         pssd_pkg::PH_COL_L: if (accept) begin
            r.kind = pssd_pkg::KIND_PALETTE;
            r.color_index = slot_ff[3:0];
            r.palette_color = {held_ff[2:0], 2'b00, b[6:4], 2'b00, b[2:0], 2'b00};
            r.last = 1'b1;
            out_in = r; outv_in = 1'b1;
            mask_in = {mask_ff[14:0], 1'b0}; slot_in = slot_ff + 5'd1;
            phase_in = pssd_pkg::PH_SEEK;
         end
         pssd_pkg::PH_VCOUNT: if (accept) begin
            held_in = b; cnt_in = '0;
            phase_in = (b == 8'd0) ? pssd_pkg::PH_DESC : pssd_pkg::PH_VXY;
         end
         pssd_pkg::PH_VXY: if (accept) begin
            // even byte is held; odd byte writes the whole entry
            if (cnt_ff[0]) begin
               vt_we = 1'b1; vt_wd = {c0_ff[7:0], b};
            end else begin
               c0_in = {8'd0, b};
            end
            cnt_in = cnt_ff + 9'd1;
            if ((cnt_ff + 9'd1) == {held_ff, 1'b0}) begin
               phase_in = pssd_pkg::PH_DESC;
            end
         end
         pssd_pkg::PH_DESC: if (accept) begin
            if (b >= pssd_pkg::MarkSceneEnd) begin
               r.kind = (b == pssd_pkg::MarkFrameEnd) ? pssd_pkg::KIND_FRAME_END :
                  ((b == pssd_pkg::MarkSkip) ? pssd_pkg::KIND_SKIP :
                   pssd_pkg::KIND_SCENE_END);
               r.last = 1'b1;
               out_in = r; outv_in = 1'b1;
               phase_in = pssd_pkg::PH_FLAGS;
            end else begin
               pcol_in = b[7:4]; pvc_in = b[3:0]; ppos_in = '0;
               if (b[3:0] != 4'd0) begin
                  phase_in = idx_mode_ff ? pssd_pkg::PH_IDX : pssd_pkg::PH_PX;
               end
            end
         end
         pssd_pkg::PH_IDX: if (accept) begin
            phase_in = pssd_pkg::PH_IDX_WB;
         end
         pssd_pkg::PH_IDX_WB: begin
            pv_we = 1'b1; pv_wd = vt_rd;
            ppos_in = ppos_ff + 4'd1;
            if ((ppos_ff + 4'd1) == pvc_ff) begin
               s_in = 4'd1; rd_k_in = '0; phase_in = pssd_pkg::PH_EMIT;
            end else begin
               phase_in = pssd_pkg::PH_IDX;
            end
         end
         pssd_pkg::PH_PX: if (accept) begin
            held_in = b; phase_in = pssd_pkg::PH_PY;
         end
         pssd_pkg::PH_PY: if (accept) begin
            pv_we = 1'b1; ppos_in = ppos_ff + 4'd1;
            if ((ppos_ff + 4'd1) == pvc_ff) begin
               s_in = 4'd1; rd_k_in = '0; phase_in = pssd_pkg::PH_EMIT;
            end else begin
               phase_in = pssd_pkg::PH_PX;
            end
         end
         pssd_pkg::PH_EMIT: begin
            // issue corner reads 0, s, s+1, end of step
            if (pvc_ff < 4'd3 || s_ff >= maxi) begin
               phase_in = pssd_pkg::PH_DESC;
            end else begin
               case (rd_k_ff)
                  2'd0: pv_ra = '0;
                  2'd1: pv_ra = s_ff;
                  2'd2: pv_ra = s_ff + 4'd1;
                  default: pv_ra = s_end;
               endcase
               phase_in = pssd_pkg::PH_EMIT_RD;
            end
         end
         pssd_pkg::PH_EMIT_RD: begin
            // capture the corner; the output register may still hold a word
            case (rd_k_ff)
               2'd0: c0_in = pv_rd;
               2'd1: c1_in = pv_rd;
               2'd2: c2_in = pv_rd;
               default: c3_in = pv_rd;
            endcase
            if (rd_k_ff == 2'd3) begin
               phase_in = pssd_pkg::PH_OUT;
            end else begin
               rd_k_in = rd_k_ff + 2'd1; phase_in = pssd_pkg::PH_EMIT;
            end
         end
         pssd_pkg::PH_OUT: if (out_free) begin
            r.kind = pssd_pkg::KIND_QUAD;
            r.x0 = c0_ff[15:8]; r.y0 = c0_ff[7:0];
            r.x1 = c1_ff[15:8]; r.y1 = c1_ff[7:0];
            r.x2 = c2_ff[15:8]; r.y2 = c2_ff[7:0];
            r.x3 = c3_ff[15:8]; r.y3 = c3_ff[7:0];
            r.color_index = pcol_ff;
            r.last = (s_end >= maxi);
            out_in = r; outv_in = 1'b1;
            s_in = s_end; rd_k_in = '0;
            phase_in = (s_end >= maxi) ? pssd_pkg::PH_DESC : pssd_pkg::PH_EMIT;
         end
         default: phase_in = pssd_pkg::PH_FLAGS;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pssd_pkg::PH_FLAGS;
         outv_ff  <= 1'b0;
         cnt_ff <= '0; idx_mode_ff <= 1'b0; mask_ff <= '0; slot_ff <= '0;
         held_ff <= '0; pcol_ff <= '0; pvc_ff <= '0; ppos_ff <= '0;
         s_ff <= '0; rd_k_ff <= '0;
      end else begin
         phase_ff <= phase_in; outv_ff <= outv_in;
         cnt_ff <= cnt_in; idx_mode_ff <= idx_mode_in; mask_ff <= mask_in;
         slot_ff <= slot_in; held_ff <= held_in; pcol_ff <= pcol_in;
         pvc_ff <= pvc_in; ppos_ff <= ppos_in; s_ff <= s_in; rd_k_ff <= rd_k_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      c0_ff <= c0_in; c1_ff <= c1_in; c2_ff <= c2_in; c3_ff <= c3_in;
   end

   assign rsp_valid         = outv_ff;
   assign rsp_result_kind   = out_ff.kind;
   assign rsp_x0 = out_ff.x0; assign rsp_y0 = out_ff.y0;
   assign rsp_x1 = out_ff.x1; assign rsp_y1 = out_ff.y1;
   assign rsp_x2 = out_ff.x2; assign rsp_y2 = out_ff.y2;
   assign rsp_x3 = out_ff.x3; assign rsp_y3 = out_ff.y3;
   assign rsp_color_index   = out_ff.color_index;
   assign rsp_palette_color = out_ff.palette_color;
   assign rsp_last          = out_ff.last;

   // no byte is taken while quads of a polygon are still going out
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pssd_pkg::PH_OUT || phase_ff == pssd_pkg::PH_EMIT) |-> req_stall)
      else $error("byte taken during quad emission");
   // a result held under stall stays valid and keeps its kind
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) |-> rsp_valid && $stable(rsp_result_kind))
      else $error("stalled result changed");
   // only quads carry corners (the check looks at x0)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != pssd_pkg::KIND_QUAD |-> rsp_x0 == 8'd0)
      else $error("corner data on non-quad result");

endmodule
`default_nettype wire

>>> verif/polygon_scene_stream_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_scene_stream_decoder_checker
// Watches both channels, predicts the result words of every accepted byte
// and compares each result word, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module polygon_scene_stream_decoder_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_result_kind,
   input  wire logic [7:0]  rsp_x0,
   input  wire logic [7:0]  rsp_y0,
   input  wire logic [7:0]  rsp_x1,
   input  wire logic [7:0]  rsp_y1,
   input  wire logic [7:0]  rsp_x2,
   input  wire logic [7:0]  rsp_y2,
   input  wire logic [7:0]  rsp_x3,
   input  wire logic [7:0]  rsp_y3,
   input  wire logic [3:0]  rsp_color_index,
   input  wire logic [14:0] rsp_palette_color,
   input  wire logic        rsp_last,
   output int               fail_count,
   output int               pending_words,
   output int               checked_words
);

   typedef enum logic [3:0] {
      ST_FLAGS, ST_MASK_H, ST_MASK_L, ST_COL_H, ST_COL_L, ST_VCOUNT, ST_VXY,
      ST_DESC, ST_IDX, ST_PX, ST_PY
   } parse_state_type;

   parse_state_type state;
   logic [8:0]      pair_bytes;
   logic            indexed;
   logic [15:0]     pal_mask;
   logic [4:0]      pal_slot;
   logic [7:0]      held;
   logic [3:0]      poly_color;
   logic [3:0]      poly_count;
   logic [3:0]      poly_pos;
   logic [15:0]     vtx_table [pssd_pkg::VtxDepth];
   logic [15:0]     corners [pssd_pkg::PolyDepth];

   pssd_pkg::result_type expected_words [$];

   function automatic pssd_pkg::result_type blank_word(pssd_pkg::kind_type k);
      pssd_pkg::result_type w;
      w = '0;
      w.kind = k;
      return w;
   endfunction

   // skip clear mask bits; leave the palette block when none remain
   task automatic seek_palette();
      while (pal_slot < 5'd16 && !pal_mask[15]) begin
         pal_mask = pal_mask << 1;
         pal_slot = pal_slot + 5'd1;
      end
      if (pal_slot < 5'd16) state = ST_COL_H;
      else state = indexed ? ST_VCOUNT : ST_DESC;
   endtask

   // fan the polygon into quads around corner 0
   task automatic fan_polygon(ref pssd_pkg::result_type words [$]);
      int                   top_idx;
      int                   s;
      pssd_pkg::result_type w;
      if (poly_count >= 4'd3) begin
         top_idx = poly_count - 1;
         s = 1;
         while (s < top_idx) begin
            w = blank_word(pssd_pkg::KIND_QUAD);
            w.color_index = poly_color;
            {w.x0, w.y0} = corners[0];
            {w.x1, w.y1} = corners[s];
            {w.x2, w.y2} = corners[s + 1];
            s = s + 2;
            if (s > top_idx) s = top_idx;
            {w.x3, w.y3} = corners[s];
            words.push_back(w);
         end
      end
   endtask

   task automatic add_corner(logic [15:0] v, ref pssd_pkg::result_type words [$]);
      corners[poly_pos] = v;
      poly_pos = poly_pos + 4'd1;
      if (poly_pos == poly_count) begin
         fan_polygon(words);
         state = ST_DESC;
      end
   endtask

   // advance the parser by one byte and queue the words it causes
   task automatic decode_byte(logic [7:0] b);
      pssd_pkg::result_type words [$];
      pssd_pkg::result_type w;
      case (state)
         ST_FLAGS: begin
            if (b[0]) words.push_back(blank_word(pssd_pkg::KIND_CLEAR));
            indexed = b[2];
            state = b[1] ? ST_MASK_H : (b[2] ? ST_VCOUNT : ST_DESC);
         end
         ST_MASK_H: begin
            held = b;
            state = ST_MASK_L;
         end
         ST_MASK_L: begin
            pal_mask = {held, b};
            pal_slot = '0;
            seek_palette();
         end
         ST_COL_H: begin
            held = b;
            state = ST_COL_L;
         end
         ST_COL_L: begin
            w = blank_word(pssd_pkg::KIND_PALETTE);
            w.color_index = pal_slot[3:0];
            w.palette_color = {held[2:0], 2'b00, b[6:4], 2'b00, b[2:0], 2'b00};
            words.push_back(w);
            pal_mask = pal_mask << 1;
            pal_slot = pal_slot + 5'd1;
            seek_palette();
         end
         ST_VCOUNT: begin
            held = b;
            pair_bytes = '0;
            state = (b == 8'd0) ? ST_DESC : ST_VXY;
         end
         ST_VXY: begin
            if (pair_bytes[0]) vtx_table[pair_bytes[8:1]][7:0] = b;
            else vtx_table[pair_bytes[8:1]][15:8] = b;
            pair_bytes = pair_bytes + 9'd1;
            if (10'(pair_bytes) == 10'(held) * 10'd2) state = ST_DESC;
         end
         ST_DESC: begin
            if (b >= pssd_pkg::MarkSceneEnd) begin
               words.push_back(blank_word(
                  b == pssd_pkg::MarkFrameEnd ? pssd_pkg::KIND_FRAME_END :
                  b == pssd_pkg::MarkSkip ? pssd_pkg::KIND_SKIP :
                  pssd_pkg::KIND_SCENE_END));
               state = ST_FLAGS;
            end else begin
               poly_color = b[7:4];
               poly_count = b[3:0];
               poly_pos = '0;
               if (b[3:0] != 4'd0) state = indexed ? ST_IDX : ST_PX;
            end
         end
         ST_IDX: add_corner(vtx_table[b], words);
         ST_PX: begin
            held = b;
            state = ST_PY;
         end
         ST_PY: begin
            state = ST_PX;
            add_corner({held, b}, words);
         end
         default: state = ST_FLAGS;
      endcase
      if (words.size() > 0) words[words.size() - 1].last = 1'b1;
      foreach (words[i]) expected_words.push_back(words[i]);
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // predict on accepted bytes, compare accepted result words
   always @(posedge clock) begin
      pssd_pkg::result_type e;
      if (reset) begin
         pair_bytes = '0;
         indexed = 1'b0;
         pal_mask = '0;
         pal_slot = '0;
         held = '0;
         poly_color = '0;
         poly_count = '0;
         poly_pos = '0;
         state = ST_FLAGS;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            checked_words++;
            if (expected_words.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               check_field("result_kind", e.kind, rsp_result_kind);
               check_field("x0", e.x0, rsp_x0);
               check_field("y0", e.y0, rsp_y0);
               check_field("x1", e.x1, rsp_x1);
               check_field("y1", e.y1, rsp_y1);
               check_field("x2", e.x2, rsp_x2);
               check_field("y2", e.y2, rsp_y2);
               check_field("x3", e.x3, rsp_x3);
               check_field("y3", e.y3, rsp_y3);
               check_field("color_index", e.color_index, rsp_color_index);
               check_field("palette_color", e.palette_color, rsp_palette_color);
               check_field("last", e.last, rsp_last);
            end
         end
      end
      pending_words = expected_words.size();
   end

   initial begin
      fail_count = 0;
      pending_words = 0;
      checked_words = 0;
   end

endmodule

>>> verif/polygon_scene_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_scene_stream_decoder_tb
// Feeds well-formed scene frames (directed, then random content) with random
// idle bursts on both sides; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module polygon_scene_stream_decoder_tb;

   localparam int IdleLimit = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_result_kind;
   logic [7:0]  rsp_x0, rsp_y0, rsp_x1, rsp_y1, rsp_x2, rsp_y2, rsp_x3, rsp_y3;
   logic [3:0]  rsp_color_index;
   logic [14:0] rsp_palette_color;
   logic        rsp_last;

   int fail_count;
   int pending_words;
   int checked_words;
   int bytes_sent;
   int frames_sent;
   int table_fill;
   int idle_cycles;
   bit quiet;

   polygon_scene_stream_decoder u_top (.*);

   polygon_scene_stream_decoder_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // stall the result side in random bursts, none in the quiet tail
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Watchdog expired");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b);
      int n;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_desc(logic [3:0] color, logic [3:0] count);
      logic [7:0] d;
      d = {color, count};
      if (d >= pssd_pkg::MarkSceneEnd) d = {4'he, count};
      return d;
   endfunction

   // one frame: flags, optional palette, optional table load, polygons, marker
   task automatic send_frame(logic [7:0] flags, logic [15:0] mask, int nload,
                             int npoly, int max_count, logic [7:0] marker);
      logic [7:0] d;
      int         cnt;
      send_byte(flags);
      if (flags[1]) begin
         send_byte(mask[15:8]);
         send_byte(mask[7:0]);
         for (int i = 15; i >= 0; i--)
            if (mask[i]) begin
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(0, 255)));
            end
      end
      if (flags[2]) begin
         send_byte(8'(nload));
         for (int i = 0; i < 2 * nload; i++) send_byte(8'($urandom_range(0, 255)));
         if (nload > table_fill) table_fill = nload;
      end
      for (int p = 0; p < npoly; p++) begin
         cnt = $urandom_range(0, max_count);
         if (flags[2] && table_fill == 0) cnt = 0;
         d = pick_desc(4'($urandom_range(0, 15)), 4'(cnt));
         send_byte(d);
         for (int v = 0; v < d[3:0]; v++) begin
            if (flags[2]) begin
               send_byte(8'($urandom_range(0, table_fill - 1)));
            end else begin
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      send_byte(marker);
      frames_sent++;
   endtask

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 2))
         0: return pssd_pkg::MarkFrameEnd;
         1: return pssd_pkg::MarkSkip;
         default: return pssd_pkg::MarkSceneEnd;
      endcase
   endfunction

   initial begin
      logic [7:0] flags;
      int         waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      quiet = 0;
      bytes_sent = 0;
      frames_sent = 0;
      table_fill = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: all flag bits, sparse and empty masks, every marker
      send_frame(8'h07, 16'h8001, 2, 2, 15, pssd_pkg::MarkFrameEnd);
      send_frame(8'hfa, 16'h0000, 0, 1, 3, pssd_pkg::MarkSkip);
      send_frame(8'h04, 16'h0000, 0, 1, 2, pssd_pkg::MarkSceneEnd);
      send_frame(8'h01, 16'h0000, 0, 2, 15, pssd_pkg::MarkFrameEnd);

      // random frames; mostly well-formed polygons with random content
      while (bytes_sent < 330) begin
         if (bytes_sent > 280) quiet = 1;
         flags = 8'($urandom_range(0, 255));
         send_frame(flags, $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom()),
                    $urandom_range(0, 8), $urandom_range(0, 5),
                    $urandom_range(0, 3) == 0 ? 2 : 15, pick_marker());
      end
      quiet = 1;
      req_valid <= 1'b0;

      // let the checker see the last accepted byte before waiting
      @(posedge clock);
      waited = 0;
      while (pending_words != 0 && waited < IdleLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d frames, checked %0d result words",
               bytes_sent, frames_sent, checked_words);
      if (fail_count == 0 && pending_words == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (pending_words != 0) $error("%0d expected words never arrived", pending_words);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
